@@ rtl/core/jtst_pkg.sv @@
// ----------------------------------------------------------------------------
// jtst_pkg
// Shared types and constants of the journal transaction slot table.
// ----------------------------------------------------------------------------
package jtst_pkg;

  // Field widths of the command and result beats
  localparam int OP_W     = 3;
  localparam int SLOT_W   = 3;
  localparam int STATUS_W = 2;
  localparam int ID_W     = 32;
  localparam int TOTAL_W  = 5;
  localparam int ACTIVE_W = 4;

  // Command codes; codes six and seven do nothing
  typedef enum logic [OP_W-1:0] {
    OP_BEGIN      = 3'd0,
    OP_ADD        = 3'd1,
    OP_COMMIT     = 3'd2,
    OP_ABORT      = 3'd3,
    OP_CHECKPOINT = 3'd4,
    OP_REINIT     = 3'd5
  } op_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 2'd0,
    ST_NO_FREE     = 2'd1,
    ST_NOT_PENDING = 2'd2,
    ST_FULL        = 2'd3
  } status_t;

  // Slot phase; aborted and completed slots are free for begin
  typedef enum logic [1:0] {
    PH_ABORTED   = 2'd0,
    PH_PENDING   = 2'd1,
    PH_COMMITTED = 2'd2,
    PH_COMPLETED = 2'd3
  } phase_t;

  // First transaction id after reset or reinitialize
  localparam logic [ID_W-1:0] FIRST_ID = 32'd1;

endpackage

@@ rtl/core/journal_transaction_slot_table_top.sv @@
// ----------------------------------------------------------------------------
// journal_transaction_slot_table_top
// Table of transaction slots driven by begin/add/commit/abort/checkpoint/
// reinitialize commands, one result beat per command.
// ----------------------------------------------------------------------------
// A command beat is taken whenever start is high; busy never rises, so a new
// command may follow in every cycle. Each command gives exactly one result
// beat: the command is held in the command register, then the table update
// and result are computed in a single pass (lowest free slot found by a
// priority encoder over the slot phase flags) and registered onto the out_
// ports. out_valid is high for that one cycle only and the result is not
// held, so the receiver must take it then. Commands see the table as left by
// every earlier command, in order.
module journal_transaction_slot_table_top #(
  parameter int SLOTS   = 8,
  parameter int MAX_OPS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [jtst_pkg::OP_W-1:0]      in_op,
  input  logic [jtst_pkg::SLOT_W-1:0]    in_slot,
  output logic                           out_valid,
  output logic [jtst_pkg::STATUS_W-1:0]  out_status,
  output logic [jtst_pkg::SLOT_W-1:0]    out_slot_index,
  output logic [jtst_pkg::ID_W-1:0]      out_txn_id,
  output logic [jtst_pkg::TOTAL_W-1:0]   out_op_total,
  output logic [jtst_pkg::ACTIVE_W-1:0]  out_active_count
);

  import jtst_pkg::*;

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int AW    = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;
  localparam int CNT_W = $clog2(MAX_OPS + 1);
  localparam int PND_W = $clog2(SLOTS + 1);

  // Command register
  logic              cmd_valid_r;
  op_t               cmd_op_r;
  logic [SLOT_W-1:0] cmd_slot_r;

  // Slot table and counters
  phase_t             phase_r   [SLOTS];
  phase_t             phase_nxt [SLOTS];
  logic [ID_W-1:0]    txn_r     [SLOTS];
  logic [ID_W-1:0]    txn_nxt   [SLOTS];
  logic [CNT_W-1:0]   count_r   [SLOTS];
  logic [CNT_W-1:0]   count_nxt [SLOTS];
  logic [ID_W-1:0]    next_id_r;
  logic [ID_W-1:0]    next_id_nxt;
  logic [PND_W-1:0]   pending_r;
  logic [PND_W-1:0]   pending_nxt;

  // Result register
  logic               res_valid_r;
  status_t            res_status_r;
  status_t            res_status_nxt;
  logic [SLOT_W-1:0]  res_slot_r;
  logic [SLOT_W-1:0]  res_slot_nxt;
  logic [ID_W-1:0]    res_id_r;
  logic [ID_W-1:0]    res_id_nxt;
  logic [TOTAL_W-1:0] res_total_r;
  logic [TOTAL_W-1:0] res_total_nxt;
  logic [PND_W-1:0]   res_active_r;

  // Addressed slot and lowest free slot
  logic [AW-1:0]    slot_ext;
  logic             slot_in_range;
  logic [IDX_W-1:0] slot_idx;
  logic             free_found;
  logic [IDX_W-1:0] free_idx;

  assign busy = 1'b0;

  // Capture command beats
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_valid_r <= 1'b0;
    end else begin
      cmd_valid_r <= start;
    end
    if (start) begin
      cmd_op_r   <= op_t'(in_op);
      cmd_slot_r <= in_slot;
    end
  end

  // Slot address decode
  assign slot_ext      = AW'(cmd_slot_r);
  assign slot_in_range = (int'(slot_ext) < SLOTS);
  assign slot_idx      = slot_ext[IDX_W-1:0];

  // Priority encoder: lowest aborted or completed slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (phase_r[i] == PH_ABORTED || phase_r[i] == PH_COMPLETED) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  // Table update and result for one command
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      phase_nxt[i] = phase_r[i];
      txn_nxt[i]   = txn_r[i];
      count_nxt[i] = count_r[i];
    end
    next_id_nxt    = next_id_r;
    pending_nxt    = pending_r;
    res_status_nxt = ST_OK;
    res_slot_nxt   = '0;
    res_id_nxt     = '0;
    res_total_nxt  = '0;

    if (cmd_valid_r) begin
      case (cmd_op_r)
        OP_BEGIN: begin
          if (free_found) begin
            phase_nxt[free_idx] = PH_PENDING;
            txn_nxt[free_idx]   = next_id_r;
            count_nxt[free_idx] = '0;
            next_id_nxt         = next_id_r + 1'b1;
            pending_nxt         = pending_r + 1'b1;
            res_slot_nxt        = SLOT_W'(free_idx);
            res_id_nxt          = next_id_r;
          end else begin
            res_status_nxt = ST_NO_FREE;
          end
        end

        OP_ADD, OP_COMMIT, OP_ABORT: begin
          res_slot_nxt = cmd_slot_r;
          if (!slot_in_range) begin
            res_status_nxt = ST_NOT_PENDING;
          end else begin
            res_id_nxt    = txn_r[slot_idx];
            res_total_nxt = TOTAL_W'(count_r[slot_idx]);
            if (phase_r[slot_idx] != PH_PENDING) begin
              res_status_nxt = ST_NOT_PENDING;
            end else if (cmd_op_r == OP_ADD) begin
              if (count_r[slot_idx] == CNT_W'(MAX_OPS)) begin
                res_status_nxt = ST_FULL;
              end else begin
                count_nxt[slot_idx] = count_r[slot_idx] + 1'b1;
                res_total_nxt       = TOTAL_W'(count_r[slot_idx] + 1'b1);
              end
            end else begin
              // Commit skips committed and goes straight to completed
              phase_nxt[slot_idx] = (cmd_op_r == OP_COMMIT) ? PH_COMPLETED
                                                           : PH_ABORTED;
              if (pending_r != '0) begin
                pending_nxt = pending_r - 1'b1;
              end
            end
          end
        end

        OP_CHECKPOINT: begin
          for (int i = 0; i < SLOTS; i++) begin
            if (phase_r[i] == PH_COMMITTED) begin
              phase_nxt[i] = PH_COMPLETED;
            end
          end
        end

        OP_REINIT: begin
          for (int i = 0; i < SLOTS; i++) begin
            phase_nxt[i] = PH_ABORTED;
            txn_nxt[i]   = '0;
            count_nxt[i] = '0;
          end
          next_id_nxt = FIRST_ID;
          pending_nxt = '0;
        end

        default: begin
          // unused codes leave the table alone
        end
      endcase
    end
  end

  // Table state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        phase_r[i] <= PH_ABORTED;
        txn_r[i]   <= '0;
        count_r[i] <= '0;
      end
      next_id_r <= FIRST_ID;
      pending_r <= '0;
    end else begin
      for (int i = 0; i < SLOTS; i++) begin
        phase_r[i] <= phase_nxt[i];
        txn_r[i]   <= txn_nxt[i];
        count_r[i] <= count_nxt[i];
      end
      next_id_r <= next_id_nxt;
      pending_r <= pending_nxt;
    end
  end

  // Result beat register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else begin
      res_valid_r <= cmd_valid_r;
    end
    if (cmd_valid_r) begin
      res_status_r <= res_status_nxt;
      res_slot_r   <= res_slot_nxt;
      res_id_r     <= res_id_nxt;
      res_total_r  <= res_total_nxt;
      res_active_r <= pending_nxt;
    end
  end

  assign out_valid        = res_valid_r;
  assign out_status       = res_status_r;
  assign out_slot_index   = res_slot_r;
  assign out_txn_id       = res_id_r;
  assign out_op_total     = res_total_r;
  assign out_active_count = ACTIVE_W'(res_active_r);

endmodule

@@ rtl/core/jtst_checker.sv @@
// ----------------------------------------------------------------------------
// jtst_checker
// Port-level checks of the journal transaction slot table, bound to the top.
// ----------------------------------------------------------------------------
module jtst_checker #(
  parameter int SLOTS = 8
) (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           start,
  input logic                           busy,
  input logic                           out_valid,
  input logic [jtst_pkg::STATUS_W-1:0]  out_status,
  input logic [jtst_pkg::SLOT_W-1:0]    out_slot_index,
  input logic [jtst_pkg::ID_W-1:0]      out_txn_id,
  input logic [jtst_pkg::TOTAL_W-1:0]   out_op_total,
  input logic [jtst_pkg::ACTIVE_W-1:0]  out_active_count
);

  import jtst_pkg::*;

  // Commands are never refused
  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !busy)
    else $error("busy raised");

  // One result beat per command, after the command and result registers
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $past(rst_n, 2) |-> out_valid == $past(start, 2))
    else $error("result beat does not match command beat");

  // A failed begin reports zero slot index, id and total
  a_no_free_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_NO_FREE
      |-> out_slot_index == '0 && out_txn_id == '0 && out_op_total == '0)
    else $error("no-free result carries slot data");

  // Pending count never exceeds the table size
  a_active_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> int'(out_active_count) <= SLOTS)
    else $error("active count beyond slot count");

  // A full slot always holds operations
  a_full_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_FULL |-> out_op_total != '0)
    else $error("full status with empty operation count");

endmodule

bind journal_transaction_slot_table_top jtst_checker #(.SLOTS(SLOTS)) u_jtst_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .out_valid        (out_valid),
  .out_status       (out_status),
  .out_slot_index   (out_slot_index),
  .out_txn_id       (out_txn_id),
  .out_op_total     (out_op_total),
  .out_active_count (out_active_count)
);
